@@ design/svnl_pkg.sv @@
package svnl_pkg;

  // token kinds as they arrive on the input word
  localparam logic [1:0] KIND_LOCAL  = 2'd0;
  localparam logic [1:0] KIND_GLOBAL = 2'd1;

  // warning codes
  localparam logic [1:0] WARN_NONE         = 2'd0;
  localparam logic [1:0] WARN_LOCAL_COLON  = 2'd1;
  localparam logic [1:0] WARN_SINGLE_COLON = 2'd2;
  localparam logic [1:0] WARN_MANY_COLONS  = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_GLOBAL_FIRST = 2'd1;
  localparam logic [1:0] ERR_MEMBER_FIRST = 2'd2;

  // character constants
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;

  localparam logic [1:0] RUN_MAX = 2'd3;

  typedef struct packed {
    logic [7:0] character;
    logic       start_req;
    logic [1:0] token_kind;
  } svnl_item_t;

  typedef struct packed {
    logic       colon_prefix;
    logic       out_valid;
    logic [7:0] out_char;
    logic       token_done;
    logic [1:0] pushback;
    logic [1:0] warning_code;
    logic [1:0] error_code;
  } svnl_res_t;

  typedef struct packed {
    logic       active;
    logic [1:0] kind_held;
    logic       colon_pending;
    logic       need_first_char;
    logic [1:0] colon_run;
    logic       last_was_colon;
    logic       colon_warned;
  } svnl_state_t;

  localparam svnl_state_t STATE_RESET = '{
    active:          1'b0,
    kind_held:       KIND_LOCAL,
    colon_pending:   1'b0,
    need_first_char: 1'b1,
    colon_run:       2'd0,
    last_was_colon:  1'b0,
    colon_warned:    1'b0
  };

endpackage

@@ design/svnl_chan_if.sv @@
interface svnl_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/svnl_step.sv @@
module svnl_step (
  input  svnl_pkg::svnl_item_t  item,
  input  svnl_pkg::svnl_state_t state,
  output svnl_pkg::svnl_res_t   res,
  output svnl_pkg::svnl_state_t state_next
);
  import svnl_pkg::*;

  logic       member;
  logic       global_name;
  logic       joined;
  logic [7:0] c;

  function automatic logic is_first(input logic [7:0] ch);
    return (ch >= CH_UP_A && ch <= CH_UP_Z) || (ch >= CH_LO_A && ch <= CH_LO_Z)
           || ch == CH_UNDER;
  endfunction

  function automatic logic is_name(input logic [7:0] ch);
    return is_first(ch) || (ch >= CH_DIG_0 && ch <= CH_DIG_9);
  endfunction

  assign c = item.character;

  always_comb begin
    state_next  = state;
    res         = '0;
    joined      = 1'b0;
    member      = 1'b0;
    global_name = 1'b0;

    // a start always opens a fresh token
    if (item.start_req) begin
      state_next                 = STATE_RESET;
      state_next.active          = 1'b1;
      state_next.kind_held       = item.token_kind;
    end

    if (state_next.active) begin
      member      = state_next.kind_held[1];
      global_name = (state_next.kind_held == KIND_GLOBAL);

      if (member) begin
        if (state_next.need_first_char) begin
          res.out_valid              = 1'b1;
          res.out_char               = c;
          state_next.need_first_char = 1'b0;
          if (!is_first(c)) begin
            res.error_code = ERR_MEMBER_FIRST;
          end
        end else if (c == CH_NUL) begin
          res.token_done = 1'b1;
        end else if (is_name(c)) begin
          res.out_valid = 1'b1;
          res.out_char  = c;
        end else begin
          res.token_done = 1'b1;
          res.pushback   = 2'd1;
        end
      end else begin
        // resolve the held colon against this character
        if (state_next.colon_pending) begin
          state_next.colon_pending = 1'b0;
          if (c == CH_COLON || is_first(c)) begin
            res.colon_prefix = 1'b1;
            joined           = state_next.last_was_colon;
            if (global_name) begin
              if (state_next.colon_run != RUN_MAX) begin
                state_next.colon_run = state_next.colon_run + 2'd1;
              end
              state_next.need_first_char = 1'b1;
            end else if (!state_next.colon_warned) begin
              res.warning_code        = WARN_LOCAL_COLON;
              state_next.colon_warned = 1'b1;
            end
          end else begin
            res.token_done = 1'b1;
            res.pushback   = 2'd2;
          end
        end
        state_next.last_was_colon = 1'b0;

        if (!res.token_done) begin
          if (c == CH_NUL) begin
            res.token_done = 1'b1;
          end else begin
            // separator run closes on the first non-colon
            if (global_name && joined && c != CH_COLON) begin
              if (state_next.colon_run == 2'd1) begin
                res.warning_code = WARN_SINGLE_COLON;
              end else if (state_next.colon_run == RUN_MAX) begin
                res.warning_code = WARN_MANY_COLONS;
              end
              state_next.colon_run = 2'd0;
            end
            if (global_name && state_next.need_first_char && c != CH_COLON) begin
              if (is_first(c)) begin
                res.out_valid              = 1'b1;
                res.out_char               = c;
                state_next.need_first_char = 1'b0;
              end else begin
                res.error_code = ERR_GLOBAL_FIRST;
              end
            end else if (is_name(c)) begin
              res.out_valid = 1'b1;
              res.out_char  = c;
            end else if (c == CH_COLON) begin
              state_next.colon_pending  = 1'b1;
              state_next.last_was_colon = 1'b1;
            end else begin
              res.token_done = 1'b1;
              res.pushback   = 2'd1;
            end
          end
        end
      end

      if (res.token_done) begin
        state_next.active = 1'b0;
      end
    end
  end

endmodule

@@ design/script_variable_name_lexer.sv @@
// channel | dir | payload                                   | handshake
// item    | in  | character, start_req, token_kind          | valid/ready
// result  | out | colon_prefix, out_valid, out_char,        | valid/ready
//         |     | token_done, pushback, warning_code,       |
//         |     | error_code                                |
//
// one result word per input word, one word per cycle sustained while result is ready
// each word passes the input register, then scan logic into the result register
// scan state updates only when a word moves from the input register to the result register
// a stalled result holds the result register; the input register still takes one more word
// rst is synchronous and clears both valid flags and the scan state
module script_variable_name_lexer (
  input logic       clk,
  input logic       rst,
  svnl_chan_if.sink   item,
  svnl_chan_if.source result
);
  import svnl_pkg::*;

  // input register
  logic        s0_valid;
  svnl_item_t  s0_item;

  // scan state carried from character to character
  svnl_state_t state;
  svnl_state_t state_next;

  // result register
  logic        r_valid;
  svnl_res_t   r_res;
  svnl_res_t   res_next;

  logic        advance;

  // move the held word on when the result register is free or being drained
  assign advance    = s0_valid && (!r_valid || result.ready);
  assign item.ready = !s0_valid || advance;

  svnl_step u_step (
    .item       (s0_item),
    .state      (state),
    .res        (res_next),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      r_valid  <= 1'b0;
      state    <= STATE_RESET;
    end else begin
      if (item.valid && item.ready) begin
        s0_valid <= 1'b1;
      end else if (advance) begin
        s0_valid <= 1'b0;
      end
      if (advance) begin
        r_valid <= 1'b1;
        state   <= state_next;
      end else if (result.ready) begin
        r_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s0_item <= item.data;
    end
    if (advance) begin
      r_res <= res_next;
    end
  end

  assign result.valid = r_valid;
  assign result.data  = r_res;

endmodule

@@ design/svnl_checker.sv @@
module svnl_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input svnl_pkg::svnl_res_t res
);
  import svnl_pkg::*;

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res))
    else $error("result word changed while stalled");

  // characters are only pushed back when the name ends
  a_pushback_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.pushback != 2'd0 |-> res.token_done)
    else $error("pushback without end of name");

  // every warning comes from a colon that joined the name
  a_warn_prefix: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.warning_code != WARN_NONE |-> res.colon_prefix)
    else $error("warning without joined colon");

  // a bad global first character is dropped, never appended
  a_global_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.error_code == ERR_GLOBAL_FIRST |-> !res.out_valid && !res.token_done)
    else $error("bad global first character appended");

  // no result word may be valid in the cycle after reset is sampled
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word right after reset");

endmodule

bind script_variable_name_lexer svnl_checker u_svnl_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .res       (result.data)
);
